>>> rtl/core/sscv_pkg.sv
// ----------------------------------------------------------------------------
// sscv_pkg
// Types and constants shared by the SAD stereo cost volume modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sscv_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 12;
  localparam int CFGW_W    = 11;
  localparam int DISP      = 16;
  localparam int DISP_W    = 4;
  localparam int WIN       = 5;
  localparam int LROWS     = 5;
  localparam int RROWS     = 6;
  localparam int MARGIN    = 16;
  localparam int RCOLS     = WIN + DISP - 1;
  localparam int SUM_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  // floor(x/25) = (x * 5243) >> 17 for x below 2^13
  localparam logic [SUM_W-1:0] RECIP25 = 13'd5243;
  localparam int               RSHIFT  = 17;

  localparam logic [CFGW_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0]  HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [7:0] left_pixel;
    logic [7:0] right_pixel;
  } in_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [11:0] pixel_y;
    logic [3:0]  disparity;
    logic [7:0]  match_cost;
    logic        last_of_pixel;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [DISP_W-1:0] disp;
    logic [SUM_W-1:0]  sum;
  } tok_t;

  typedef logic [WIN-1:0][7:0] pcol_t;

endpackage

`default_nettype wire

>>> rtl/core/sad_stereo_cost_volume.sv
// ----------------------------------------------------------------------------
// sad_stereo_cost_volume
// 5x5 SAD stereo matching cost volume over a raster stream of pixel pairs.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): one left/right pixel pair per
// transfer in raster order. Each pair is written into row stores (five left,
// six right rows, one RAM per row) and one column of each image is shifted
// into register windows. For an interior pixel a token per disparity runs
// through a chain of five cells, one per window column, each adding five
// absolute differences; the sum is divided by 25 into the output register.
// Output channel (out_valid/out_ready/out_data): 16 transfers per interior
// pixel, disparity 0 first, last_of_pixel set on disparity 15.
// Each pair passes through a load and a previous-row read state; a border
// pixel then returns to idle, while an interior pixel issues its 16 tokens,
// one disparity per cycle unless the output stalls, then drains the chain.
// Output stall freezes the whole cell chain; input is held off until the
// chain is empty. Config (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready. Reset clears counters, chain and sets width 640, height 480;
// row stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_stereo_cost_volume (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire sscv_pkg::in_t                       in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output sscv_pkg::out_t                           out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sscv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sscv_pkg::CFG_DAT_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_PREV, S_RUN, S_DRAIN} state_t;

  state_t                          state_r;
  logic [sscv_pkg::CFGW_W-1:0]     width_r;
  logic [sscv_pkg::ROW_W-1:0]      height_r;
  logic [sscv_pkg::CFGW_W-1:0]     w_eff;
  logic [sscv_pkg::ROW_W-1:0]      h_eff;
  logic [sscv_pkg::COL_W-1:0]      col_r;
  logic [sscv_pkg::ROW_W-1:0]      row_r;
  logic [2:0]                      lslot_r;
  logic [2:0]                      rslot_r;
  logic [2:0]                      it_lslot_r;
  logic [2:0]                      it_rslot_r;
  logic [sscv_pkg::COL_W-1:0]      it_x_r;
  logic [sscv_pkg::ROW_W-1:0]      it_y_r;
  logic                            it_int_r;
  logic                            it_edge_r;
  sscv_pkg::in_t                   it_pix_r;
  logic [sscv_pkg::DISP_W-1:0]     dcnt_r;

  logic                            in_acc;
  logic                            adv;
  logic                            interior;
  logic                            col_wrap;
  logic [sscv_pkg::CFGW_W-1:0]     col_inc;
  logic [sscv_pkg::CFGW_W-1:0]     col_p14;
  logic [sscv_pkg::ROW_W:0]        row_p14;
  logic [sscv_pkg::COL_W-1:0]      raddr;
  logic [sscv_pkg::CFGW_W-1:0]     wm1;

  logic [7:0]                      l_rd [sscv_pkg::LROWS];
  logic [7:0]                      r_rd [sscv_pkg::RROWS];

  sscv_pkg::pcol_t                 lnew;
  sscv_pkg::pcol_t                 rnew;
  sscv_pkg::pcol_t                 rprev_nxt;
  sscv_pkg::pcol_t                 rprev_r;
  sscv_pkg::pcol_t [sscv_pkg::WIN-1:0]   lwin_r;
  sscv_pkg::pcol_t [sscv_pkg::RCOLS-1:0] rwin_r;

  sscv_pkg::tok_t                  tok [sscv_pkg::WIN+1];
  sscv_pkg::pcol_t [sscv_pkg::DISP-1:0]  rcand [sscv_pkg::WIN];
  logic [2*sscv_pkg::SUM_W-1:0]    prod;

  // effective sizes
  always_comb begin
    if (width_r == '0) begin
      w_eff = 11'd1;
    end else if (width_r > 11'(sscv_pkg::MAX_WIDTH)) begin
      w_eff = 11'(sscv_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? 12'd1 : height_r;
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign adv       = !out_valid || out_ready;

  assign col_inc  = {1'b0, col_r} + 11'd1;
  assign col_wrap = (col_inc >= w_eff);
  assign col_p14  = {1'b0, col_r} + 11'd14;
  assign row_p14  = {1'b0, row_r} + 13'd14;
  assign interior = (col_r >= 10'd18) && (col_p14 < w_eff) &&
                    (row_r >= 12'd18) && (row_p14 < {1'b0, h_eff});
  assign wm1      = w_eff - 11'd1;
  assign raddr    = (state_r == S_LOAD) ? wm1[sscv_pkg::COL_W-1:0] : col_r;

  // row stores
  for (genvar s = 0; s < sscv_pkg::LROWS; s++) begin : g_lram
    sscv_ram #(.WIDTH(8), .DEPTH(sscv_pkg::MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (in_acc && (lslot_r == 3'(s))),
      .waddr (col_r),
      .wdata (in_data.left_pixel),
      .raddr (raddr),
      .rdata (l_rd[s])
    );
  end

  for (genvar s = 0; s < sscv_pkg::RROWS; s++) begin : g_rram
    sscv_ram #(.WIDTH(8), .DEPTH(sscv_pkg::MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (in_acc && (rslot_r == 3'(s))),
      .waddr (col_r),
      .wdata (in_data.right_pixel),
      .raddr (raddr),
      .rdata (r_rd[s])
    );
  end

  // new window columns; window row i is raster row r-4+i
  always_comb begin
    logic [3:0] ls;
    logic [3:0] rs;
    logic [3:0] ps;
    for (int i = 0; i < sscv_pkg::WIN; i++) begin
      ls = {1'b0, it_lslot_r} + 4'd1 + 4'(i);
      if (ls >= 4'd5) ls = ls - 4'd5;
      rs = {1'b0, it_rslot_r} + 4'd2 + 4'(i);
      if (rs >= 4'd6) rs = rs - 4'd6;
      ps = {1'b0, it_rslot_r} + 4'd1 + 4'(i);
      if (ps >= 4'd6) ps = ps - 4'd6;
      lnew[i]      = l_rd[ls[2:0]];
      rnew[i]      = r_rd[rs[2:0]];
      rprev_nxt[i] = r_rd[ps[2:0]];
    end
    lnew[sscv_pkg::WIN-1] = it_pix_r.left_pixel;
    rnew[sscv_pkg::WIN-1] = it_pix_r.right_pixel;
  end

  // right candidates: cell k, disparity d reads column c-4+k-d
  always_comb begin
    for (int k = 0; k < sscv_pkg::WIN; k++) begin
      for (int d = 0; d < sscv_pkg::DISP; d++) begin
        rcand[k][d] = rwin_r[sscv_pkg::WIN-1-k+d];
      end
    end
    if (it_edge_r) begin
      rcand[0][sscv_pkg::DISP-1] = rprev_r;
    end
  end

  assign tok[0].valid = (state_r == S_RUN);
  assign tok[0].disp  = dcnt_r;
  assign tok[0].sum   = '0;

  for (genvar k = 0; k < sscv_pkg::WIN; k++) begin : g_cell
    sscv_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .lcol    (lwin_r[k]),
      .rcand   (rcand[k]),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  assign prod = tok[sscv_pkg::WIN].sum * sscv_pkg::RECIP25;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      width_r   <= sscv_pkg::WIDTH_RST;
      height_r  <= sscv_pkg::HEIGHT_RST;
      col_r     <= '0;
      row_r     <= '0;
      lslot_r   <= '0;
      rslot_r   <= '0;
      dcnt_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sscv_pkg::REG_WIDTH:  width_r  <= cfg_data[sscv_pkg::CFGW_W-1:0];
          sscv_pkg::REG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end

      if (adv) begin
        out_valid <= tok[sscv_pkg::WIN].valid;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_LOAD;
            if (col_wrap) begin
              col_r <= '0;
              if ({1'b0, row_r} + 13'd1 >= {1'b0, h_eff}) begin
                row_r   <= '0;
                lslot_r <= '0;
                rslot_r <= '0;
              end else begin
                row_r   <= row_r + 12'd1;
                lslot_r <= (lslot_r == 3'd4) ? 3'd0 : lslot_r + 3'd1;
                rslot_r <= (rslot_r == 3'd5) ? 3'd0 : rslot_r + 3'd1;
              end
            end else begin
              col_r <= col_inc[sscv_pkg::COL_W-1:0];
            end
          end
        end
        S_LOAD: begin
          state_r <= S_PREV;
        end
        S_PREV: begin
          dcnt_r  <= '0;
          state_r <= it_int_r ? S_RUN : S_IDLE;
        end
        S_RUN: begin
          if (adv) begin
            dcnt_r <= dcnt_r + 4'd1;
            if (dcnt_r == 4'(sscv_pkg::DISP-1)) begin
              state_r <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (!tok[1].valid && !tok[2].valid && !tok[3].valid &&
              !tok[4].valid && !tok[5].valid) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // item capture, windows and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      it_pix_r   <= in_data;
      it_lslot_r <= lslot_r;
      it_rslot_r <= rslot_r;
      it_x_r     <= col_r - 10'd2;
      it_y_r     <= row_r - 12'd2;
      it_int_r   <= interior;
      it_edge_r  <= (col_r == 10'd18);
    end
    if (state_r == S_LOAD) begin
      for (int k = 0; k < sscv_pkg::WIN - 1; k++) begin
        lwin_r[k] <= lwin_r[k+1];
      end
      lwin_r[sscv_pkg::WIN-1] <= lnew;
      for (int j = sscv_pkg::RCOLS - 1; j > 0; j--) begin
        rwin_r[j] <= rwin_r[j-1];
      end
      rwin_r[0] <= rnew;
    end
    if (state_r == S_PREV) begin
      rprev_r <= rprev_nxt;
    end
    if (adv) begin
      out_data.pixel_x       <= it_x_r;
      out_data.pixel_y       <= it_y_r;
      out_data.disparity     <= tok[sscv_pkg::WIN].disp;
      out_data.match_cost    <= prod[sscv_pkg::RSHIFT+7:sscv_pkg::RSHIFT];
      out_data.last_of_pixel <= (tok[sscv_pkg::WIN].disp == 4'(sscv_pkg::DISP-1));
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sscv_ram.sv
// ----------------------------------------------------------------------------
// sscv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sscv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/sscv_cell.sv
// ----------------------------------------------------------------------------
// sscv_cell
// One window column of the SAD chain: adds five absolute differences for the
// disparity carried by the token and hands the partial sum on.
// ----------------------------------------------------------------------------
`default_nettype none

module sscv_cell (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                adv,
  input  wire sscv_pkg::pcol_t                     lcol,
  input  wire sscv_pkg::pcol_t [sscv_pkg::DISP-1:0] rcand,
  input  wire sscv_pkg::tok_t                      tok_in,
  output sscv_pkg::tok_t                           tok_out
);

  sscv_pkg::pcol_t              rsel;
  logic [7:0]                   ad [sscv_pkg::WIN];
  logic [sscv_pkg::SUM_W-1:0]   sum_nxt;
  sscv_pkg::tok_t               tok_r;

  always_comb begin
    rsel    = rcand[tok_in.disp];
    sum_nxt = tok_in.sum;
    for (int i = 0; i < sscv_pkg::WIN; i++) begin
      ad[i]   = (lcol[i] > rsel[i]) ? (lcol[i] - rsel[i]) : (rsel[i] - lcol[i]);
      sum_nxt = sum_nxt + {5'd0, ad[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r.valid <= tok_in.valid;
      tok_r.disp  <= tok_in.disp;
      tok_r.sum   <= sum_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire
